// ===== hdl/hsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// hsfp_pkg
// Shared widths, register indexes and types for the five-point heat stencil.
// ----------------------------------------------------------------------------
package hsfp_pkg;

  localparam int TEMP_W      = 32;   // Q16.16 sample
  localparam int FRAC_W      = 16;   // fraction bits of sample and weights
  localparam int IDX_W       = 11;   // row / column index on the result word
  localparam int COEFF_W     = 16;   // unsigned Q0.16 weight
  localparam int CFG_DATA_W  = 16;   // widest register
  localparam int CFG_ADDR_W  = 2;
  localparam int DIFF_W      = 34;   // up + down - 2*old, exact
  localparam int PROD_W      = 51;   // weight * difference, exact
  localparam int ACC_W       = 52;   // sum of both products
  localparam int Q_W         = ACC_W - FRAC_W;  // rounded weighted sum
  localparam int SUM_W       = Q_W + 1;         // old + q before saturation
  localparam int OUT_TDATA_W = 56;   // temp_out, out_row, out_col, padded

  localparam logic [IDX_W-1:0] DIM_RESET = 11'd1024;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COEFF_ROWS    = 2'd0,
    REG_COEFF_COLS    = 2'd1,
    REG_INTERIOR_ROWS = 2'd2,
    REG_INTERIOR_COLS = 2'd3
  } cfg_reg_t;

  // position tag that rides along with a sample down the pipe
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } pos_t;

endpackage

// ===== hdl/heat_stencil_five_point.sv =====
// ----------------------------------------------------------------------------
// heat_stencil_five_point
// Streaming five-point FTCS heat update over a raster-ordered grid with halo.
// ----------------------------------------------------------------------------
// The previous grid streams in on s_* one Q16.16 sample per word, raster
// order, halo included: (interior_rows+2) rows of (interior_cols+2) words.
// s_tuser marks the first word of a grid; the position counters also wrap
// on their own after the last halo word. For each interior point the block
// returns old + cr*(up - 2*old + down) + cc*(left - 2*old + right), rounded
// to nearest (ties up) and saturated, once the word directly below the point
// has arrived; halo points give no result. Throughput is one word per clock
// with no gaps, as long as m_tready stays high; a low m_tready while a result
// word waits on m_* stalls the whole pipe. The accepted word below a point
// passes through stages 1 to 4 and the output register before its result
// appears on m_*. The rate is set by the middle line store, which serves
// two reads (center, right neighbor) and one write per clock; the upper line
// store serves one read and one write. No clearing pass is needed after
// reset. Program the coefficients and sizes only while the stream is idle.
// ----------------------------------------------------------------------------
module heat_stencil_five_point #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [hsfp_pkg::TEMP_W-1:0]            s_tdata,   // [31:0] temp_in
  input  logic                                   s_tuser,   // [0] frame_start
  // result stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // [31:0] temp_out, [42:32] out_row, [53:43] out_col, [55:54] zero
  output logic [hsfp_pkg::OUT_TDATA_W-1:0]       m_tdata,
  output logic                                   m_tlast,   // last_of_grid
  // configuration writes
  input  logic                                   cfg_we,
  input  logic [hsfp_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [hsfp_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int DEPTH = MAX_COLS + 2;           // line store entries
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_COLS + 3);   // column counter
  localparam int RW    = $clog2(MAX_ROWS + 3);   // row counter
  localparam int TW    = hsfp_pkg::TEMP_W;
  localparam int DW    = hsfp_pkg::DIFF_W;
  localparam int PW    = hsfp_pkg::PROD_W;
  localparam int IW    = hsfp_pkg::IDX_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [hsfp_pkg::COEFF_W-1:0] coeff_rows;
  logic [hsfp_pkg::COEFF_W-1:0] coeff_cols;
  logic [IW-1:0]                interior_rows;
  logic [IW-1:0]                interior_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_rows    <= '0;
      coeff_cols    <= '0;
      interior_rows <= hsfp_pkg::DIM_RESET;
      interior_cols <= hsfp_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (hsfp_pkg::cfg_reg_t'(cfg_addr))
        hsfp_pkg::REG_COEFF_ROWS:    coeff_rows    <= cfg_wdata;
        hsfp_pkg::REG_COEFF_COLS:    coeff_cols    <= cfg_wdata;
        hsfp_pkg::REG_INTERIOR_ROWS: interior_rows <= cfg_wdata[IW-1:0];
        hsfp_pkg::REG_INTERIOR_COLS: interior_cols <= cfg_wdata[IW-1:0];
        default: ;
      endcase
    end
  end

  // zero means one, anything above the build maximum means the maximum
  logic [RW-1:0] rows_eff, rows_end;
  logic [CW-1:0] cols_eff, cols_end;

  always_comb begin
    if (interior_rows == '0) begin
      rows_eff = RW'(1);
    end else if (32'(interior_rows) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(interior_rows);
    end
    if (interior_cols == '0) begin
      cols_eff = CW'(1);
    end else if (32'(interior_cols) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(interior_cols);
    end
    rows_end = rows_eff + RW'(1);   // last halo row
    cols_end = cols_eff + CW'(1);   // last halo column
  end

  // --------------------------------------------------------------------------
  // flow control: the whole pipe moves together, held only by the output reg
  // --------------------------------------------------------------------------
  logic en;
  logic accept;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;

  // --------------------------------------------------------------------------
  // raster position
  // --------------------------------------------------------------------------
  logic [RW-1:0] row_cnt, r_cur, row_next;
  logic [CW-1:0] col_cnt, c_cur, col_next, c_plus;
  logic          col_wrap;
  logic          emit;
  hsfp_pkg::pos_t pos_cur;
  logic [AW-1:0] rd_addr_c, rd_addr_r;

  always_comb begin
    c_cur = s_tuser ? '0 : col_cnt;
    r_cur = s_tuser ? '0 : row_cnt;
    // bound shrank since the last word
    if (c_cur > cols_end) c_cur = '0;
    if (r_cur > rows_end) r_cur = '0;

    col_wrap = (c_cur == cols_end);
    col_next = col_wrap ? '0 : c_cur + CW'(1);
    if (col_wrap) begin
      row_next = (r_cur == rows_end) ? '0 : r_cur + RW'(1);
    end else begin
      row_next = r_cur;
    end

    emit = (r_cur >= RW'(2)) && (c_cur != '0) && (c_cur <= cols_eff);
    pos_cur.row  = IW'(r_cur - RW'(1));
    pos_cur.col  = IW'(c_cur);
    pos_cur.last = (r_cur == rows_end) && (c_cur == cols_eff);

    rd_addr_c = c_cur[AW-1:0];
    c_plus    = c_cur + CW'(1);
    // right neighbor of the last halo column is never used
    rd_addr_r = (c_plus < CW'(DEPTH)) ? c_plus[AW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (accept) begin
      row_cnt <= row_next;
      col_cnt <= col_next;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: line store read data arrives; neighbors resolved, writeback
  // --------------------------------------------------------------------------
  logic           s1_valid;
  logic           s1_emit;
  hsfp_pkg::pos_t s1_pos;
  logic [TW-1:0]  s1_sample;
  logic [AW-1:0]  s1_addr;

  logic [TW-1:0]  mid_mem   [DEPTH];   // previous row
  logic [TW-1:0]  above_mem [DEPTH];   // row before that
  logic [TW-1:0]  mid_rd_c, mid_rd_r, above_rd;
  logic [TW-1:0]  mid_fwd, above_fwd;
  logic           fwd_c, fwd_r;
  logic [TW-1:0]  centre, right_nb, up_nb, left_nb;
  logic           mem_we;

  assign mem_we = en && s1_valid;

  // reads see the store before this edge's writeback; bypass catches a
  // writeback to the address being read (column restart on frame start)
  always_comb begin
    centre   = fwd_c ? mid_fwd   : mid_rd_c;
    right_nb = fwd_r ? mid_fwd   : mid_rd_r;
    up_nb    = fwd_c ? above_fwd : above_rd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_rd_c  <= mid_mem[rd_addr_c];
      mid_rd_r  <= mid_mem[rd_addr_r];
      above_rd  <= above_mem[rd_addr_c];
      mid_fwd   <= s1_sample;
      above_fwd <= centre;
    end
    if (mem_we) begin
      mid_mem[s1_addr]   <= s1_sample;
      above_mem[s1_addr] <= centre;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_c    <= 1'b0;
      fwd_r    <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
      fwd_c    <= mem_we && (s1_addr == rd_addr_c);
      fwd_r    <= mem_we && (s1_addr == rd_addr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_emit   <= emit;
      s1_pos    <= pos_cur;
      s1_sample <= s_tdata;
      s1_addr   <= rd_addr_c;
    end
    // left neighbor is the previous word's center
    if (mem_we) left_nb <= centre;
  end

  function automatic logic signed [DW-1:0] sx_diff(input logic [TW-1:0] v);
    sx_diff = {{(DW - TW){v[TW-1]}}, v};
  endfunction

  logic signed [DW-1:0] dv, dh;

  always_comb begin
    dv = sx_diff(up_nb)   + sx_diff(s1_sample) - (sx_diff(centre) <<< 1);
    dh = sx_diff(left_nb) + sx_diff(right_nb)  - (sx_diff(centre) <<< 1);
  end

  // --------------------------------------------------------------------------
  // stage 2: differences registered
  // --------------------------------------------------------------------------
  logic                 s2_valid;
  logic signed [DW-1:0] s2_dv, s2_dh;
  logic [TW-1:0]        s2_old;
  hsfp_pkg::pos_t       s2_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dv  <= dv;
      s2_dh  <= dh;
      s2_old <= centre;
      s2_pos <= s1_pos;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: weight products (17 x 34 signed each)
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] cr_x, cc_x, dv_x, dh_x;
  logic                 s3_valid;
  logic signed [PW-1:0] s3_pv, s3_ph;
  logic [TW-1:0]        s3_old;
  hsfp_pkg::pos_t       s3_pos;

  always_comb begin
    cr_x = {{(PW - hsfp_pkg::COEFF_W){1'b0}}, coeff_rows};
    cc_x = {{(PW - hsfp_pkg::COEFF_W){1'b0}}, coeff_cols};
    dv_x = {{(PW - DW){s2_dv[DW-1]}}, s2_dv};
    dh_x = {{(PW - DW){s2_dh[DW-1]}}, s2_dh};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pv  <= cr_x * dv_x;
      s3_ph  <= cc_x * dh_x;
      s3_old <= s2_old;
      s3_pos <= s2_pos;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: sum and round to Q16.16 (add half, floor)
  // --------------------------------------------------------------------------
  localparam int AW2 = hsfp_pkg::ACC_W;
  localparam int QW  = hsfp_pkg::Q_W;

  logic signed [AW2-1:0] acc;
  logic                  s4_valid;
  logic signed [QW-1:0]  s4_q;
  logic [TW-1:0]         s4_old;
  hsfp_pkg::pos_t        s4_pos;

  always_comb begin
    acc = {{(AW2 - PW){s3_pv[PW-1]}}, s3_pv} + {{(AW2 - PW){s3_ph[PW-1]}}, s3_ph}
        + (AW2'(1) <<< (hsfp_pkg::FRAC_W - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_q   <= acc[AW2-1:hsfp_pkg::FRAC_W];
      s4_old <= s3_old;
      s4_pos <= s3_pos;
    end
  end

  // --------------------------------------------------------------------------
  // output register: add old, saturate
  // --------------------------------------------------------------------------
  localparam int SW = hsfp_pkg::SUM_W;

  logic signed [SW-1:0] sum;
  logic [TW-1:0]        temp_sat;

  always_comb begin
    sum = {{(SW - TW){s4_old[TW-1]}}, s4_old} + {s4_q[QW-1], s4_q};
    if (sum[SW-1:TW-1] == '0 || sum[SW-1:TW-1] == '1) begin
      temp_sat = sum[TW-1:0];
    end else if (sum[SW-1]) begin
      temp_sat = {1'b1, {(TW - 1){1'b0}}};
    end else begin
      temp_sat = {1'b0, {(TW - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {{(hsfp_pkg::OUT_TDATA_W - TW - 2 * IW){1'b0}},
                  s4_pos.col, s4_pos.row, temp_sat};
      m_tlast <= s4_pos.last;
    end
  end

endmodule

// ===== hdl/hsfp_checker.sv =====
// ----------------------------------------------------------------------------
// hsfp_checker
// Port-level checks for the five-point heat stencil, bound to the top level.
// ----------------------------------------------------------------------------
module hsfp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [hsfp_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input logic                                m_tlast
);

  localparam int TW = hsfp_pkg::TEMP_W;
  localparam int IW = hsfp_pkg::IDX_W;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  // pipe is several stages deep: nothing comes out right after reset
  a_reset_drain: assert property (@(posedge clk)
    rst |=> !m_tvalid ##1 !m_tvalid)
    else $error("result word too soon after reset");

  // results are interior points only
  a_interior: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[TW+IW-1:TW] != '0 && m_tdata[TW+2*IW-1:TW+IW] != '0)
    else $error("result on a halo position");

  // a stall at the output backs up the input side
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

endmodule

bind heat_stencil_five_point hsfp_checker u_hsfp_checker (.*);

// ===== tb/stencil_check_pkg.sv =====
// ----------------------------------------------------------------------------
// stencil_check_pkg
// Expected-result scoreboard for the five-point heat stencil testbench.
// ----------------------------------------------------------------------------
// Keeps its own copy of the line stores, window, position counters and
// registers, works out the grid point each input word completes, and
// compares result words against the oldest point still due.
// ----------------------------------------------------------------------------
package stencil_check_pkg;

  import hsfp_pkg::*;

  localparam int GRID_MAX   = 1024;
  localparam int LINE_DEPTH = GRID_MAX + 2;

  typedef struct {
    logic [TEMP_W-1:0] temp;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
  } grid_point_t;

  class heat_update_scoreboard;

    longint            wt_rows;
    longint            wt_cols;
    int                dim_rows;
    int                dim_cols;
    logic [TEMP_W-1:0] line_above  [LINE_DEPTH];
    logic [TEMP_W-1:0] line_middle [LINE_DEPTH];
    logic [TEMP_W-1:0] win_left;
    logic [TEMP_W-1:0] win_mid;
    logic [TEMP_W-1:0] win_right;
    int                row_pos;
    int                col_pos;
    grid_point_t       points_due [$];
    int                mismatches;
    int                points_checked;

    function new();
      wt_rows        = 0;
      wt_cols        = 0;
      dim_rows       = int'(DIM_RESET);
      dim_cols       = int'(DIM_RESET);
      win_left       = '0;
      win_mid        = '0;
      win_right      = '0;
      row_pos        = 0;
      col_pos        = 0;
      mismatches     = 0;
      points_checked = 0;
      foreach (line_above[k]) begin
        line_above[k]  = '0;
        line_middle[k] = '0;
      end
    endfunction

    // zero counts as one, anything past the store size as the maximum
    static function int clamp_dim(int v);
      if (v == 0) return 1;
      if (v > GRID_MAX) return GRID_MAX;
      return v;
    endfunction

    static function longint sx(logic [TEMP_W-1:0] v);
      return longint'($signed(v));
    endfunction

    function int grid_words();
      return (clamp_dim(dim_rows) + 2) * (clamp_dim(dim_cols) + 2);
    endfunction

    function int pending();
      return points_due.size();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_COEFF_ROWS:    wt_rows  = longint'(v);
        REG_COEFF_COLS:    wt_cols  = longint'(v);
        REG_INTERIOR_ROWS: dim_rows = int'(v[IDX_W-1:0]);
        REG_INTERIOR_COLS: dim_cols = int'(v[IDX_W-1:0]);
        default: ;
      endcase
    endfunction

    // exact weighted sum, round half up to Q16.16, add old, saturate
    function logic [TEMP_W-1:0] ftcs(longint old, longint up, longint down,
                                     longint left, longint right);
      longint dv;
      longint dh;
      longint acc;
      longint q;
      longint r;
      dv  = up - 2 * old + down;
      dh  = left - 2 * old + right;
      acc = wt_rows * dv + wt_cols * dh;
      q   = (acc + 64'sd32768) >>> FRAC_W;
      r   = old + q;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[TEMP_W-1:0];
    endfunction

    function void note_word(logic [TEMP_W-1:0] sample, logic first);
      int                rows;
      int                cols;
      int                r;
      int                c;
      logic [TEMP_W-1:0] up;
      grid_point_t       p;
      rows = clamp_dim(dim_rows);
      cols = clamp_dim(dim_cols);
      if (first) begin
        row_pos = 0;
        col_pos = 0;
      end
      if (col_pos >= cols + 2) col_pos = 0;
      if (row_pos >= rows + 2) row_pos = 0;
      r = row_pos;
      c = col_pos;
      win_left  = win_mid;
      win_mid   = line_middle[c];
      win_right = (c + 1 < LINE_DEPTH) ? line_middle[c + 1] : '0;
      up        = line_above[c];
      if (r >= 2 && c >= 1 && c <= cols) begin
        p.temp = ftcs(sx(win_mid), sx(up), sx(sample), sx(win_left), sx(win_right));
        p.row  = IDX_W'(r - 1);
        p.col  = IDX_W'(c);
        p.last = (r == rows + 1) && (c == cols);
        points_due.push_back(p);
      end
      line_above[c]  = line_middle[c];
      line_middle[c] = sample;
      col_pos = c + 1;
      if (col_pos >= cols + 2) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= rows + 2) row_pos = 0;
      end
    endfunction

    function void check_word(logic [OUT_TDATA_W-1:0] word, logic last);
      grid_point_t       p;
      logic [TEMP_W-1:0] t;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      t   = word[TEMP_W-1:0];
      row = word[TEMP_W +: IDX_W];
      col = word[TEMP_W + IDX_W +: IDX_W];
      if (points_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: temp %h row %0d col %0d last %b",
                   t, row, col, last);
        return;
      end
      p = points_due.pop_front();
      points_checked++;
      if (t !== p.temp || row !== p.row || col !== p.col || last !== p.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected temp %h row %0d col %0d last %b, ",
                    "got temp %h row %0d col %0d last %b"},
                   p.temp, p.row, p.col, p.last, t, row, col, last);
      end
    endfunction

  endclass

endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking stream testbench for the five-point heat stencil.
// ----------------------------------------------------------------------------
// Streams temperature grids (halo included) into the block and checks every
// updated interior point against a scoreboard that tracks the line stores
// and window itself. Covers saturation corners, a tall one-column grid whose
// row register clamps to the maximum, size register clamping, grids that
// wrap without a start mark, restarts mid-grid, truncated grids and size
// changes while mid-grid, all under random idling on both sides and a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import hsfp_pkg::*;
  import stencil_check_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_WORDS   = 1300;
  localparam int TALL_WORDS     = 150;   // first 50 rows of a tall grid
  localparam int SETTLE_CYCLES  = 12;    // pipe is five deep, leave margin
  localparam int RX_HOLD_CYCLES = 600;
  localparam int STALL_LIMIT    = 5000;  // cycles with no word moving

  // corner grid for 2 x 3 interior: rails side by side so that full-scale
  // weights drive results into both saturation limits
  localparam logic [TEMP_W-1:0] EDGE_GRID [20] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
    32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000
  };

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [TEMP_W-1:0]      s_tdata   = '0;   // [31:0] temp_in
  logic                   s_tuser   = 1'b0; // [0] frame_start
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  // [31:0] temp_out, [42:32] out_row, [53:43] out_col, [55:54] zero
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;          // last_of_grid
  logic                   cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  heat_update_scoreboard sb;

  bit                tx_gaps     = 1'b0;  // sender idles between words
  bit                rx_gaps     = 1'b0;  // receiver stalls at random
  bit                rx_hold_req = 1'b0;  // one long receiver hold-off
  logic [TEMP_W-1:0] field_base  = '0;    // smooth level of current grid
  int                words_sent  = 0;
  int                phases      = 0;
  int                quiet_cycles = 0;

  heat_stencil_five_point #(
    .MAX_ROWS(GRID_MAX),
    .MAX_COLS(GRID_MAX)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Both handshakes are observed here at the rising edge. The input word is
  // noted before the result is checked, so the outcome never depends on
  // process order within the time step.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_word(s_tdata, s_tuser);
      if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
    end
  end

  // Watchdog: a run of cycles with no word moving on either side ends it.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d points still due",
                 quiet_cycles, sb.pending());
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Sample mix: rails, full-range noise, and a smooth field around a level
  // so that many results stay clear of saturation.
  function automatic logic [TEMP_W-1:0] rand_temp();
    int p;
    p = $urandom_range(0, 99);
    if (p < 10) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (p < 35) return $urandom();
    return field_base + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coeff();
    int p;
    p = $urandom_range(0, 99);
    if (p < 15) return '0;
    if (p < 30) return '1;
    if (p < 40) return 16'd1;
    if (p < 75) return CFG_DATA_W'($urandom_range(0, 16'h4000));
    return CFG_DATA_W'($urandom());
  endfunction

  // Small grids keep the run short; zero and junk upper bits are exercised.
  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int p;
    p = $urandom_range(0, 99);
    if (p < 10) return '0;
    if (p < 18) return 16'hF800 | CFG_DATA_W'($urandom_range(1, 5));
    if (p < 80) return CFG_DATA_W'($urandom_range(1, 6));
    return CFG_DATA_W'($urandom_range(7, 20));
  endfunction

  // Register write; only issued while the stream is idle.
  task automatic set_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    sb.write_reg(idx, v);
  endtask

  // Offer one word, entered and left at a falling edge. tvalid stays high
  // on return so back-to-back words never toggle it within one step.
  task automatic send_word(input logic [TEMP_W-1:0] sample, input logic first);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    @(negedge clk);
  endtask

  // noisy grids drop stray frame_start marks that restart the counters
  task automatic send_grid(input int words, input bit mark_first, input bit noisy);
    logic first;
    field_base = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
    for (int k = 0; k < words; k++) begin
      first = (k == 0 && mark_first) || (noisy && $urandom_range(0, 39) == 0);
      send_word(rand_temp(), first);
    end
  endtask

  // Sender pauses until every due point has come back, then lets the pipe
  // run dry of halo words before anything is reprogrammed.
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    phases++;
  endtask

  // Receiver: runs of ready and stall; on request one long hold-off that
  // it counts itself while the sender keeps pushing.
  initial begin
    int ready_left;
    int stall_left;
    ready_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      if (ready_left > 0) begin
        m_tready <= 1'b1;
        ready_left--;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        ready_left = $urandom_range(0, 23);
        stall_left = rx_gaps ? pick_gap() : 0;
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int random_start;
    int full;
    int grids;
    int kind;
    sb = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed: full-scale weights on a 2 x 3 grid of rail values, then a
    // second grid that follows with no frame_start (counters wrap on their own).
    set_reg(REG_COEFF_ROWS, '1);
    set_reg(REG_COEFF_COLS, '1);
    set_reg(REG_INTERIOR_ROWS, 16'd2);
    set_reg(REG_INTERIOR_COLS, 16'd3);
    foreach (EDGE_GRID[k]) send_word(EDGE_GRID[k], k == 0);
    send_grid(sb.grid_words(), 1'b0, 1'b0);
    finish_phase();

    // Tall grid, one column: 0xFFFF masks to 2047 rows and clamps to the
    // maximum, columns 0 reads as 1. Only its first rows are streamed, so
    // row indexes run well past the small random sizes.
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    set_reg(REG_INTERIOR_ROWS, 16'hFFFF);
    set_reg(REG_INTERIOR_COLS, 16'd0);
    set_reg(REG_COEFF_ROWS, 16'h8000);
    set_reg(REG_COEFF_COLS, 16'h3039);
    send_grid(TALL_WORDS, 1'b1, 1'b0);
    finish_phase();

    // Back-pressure: receiver holds off while words keep coming at full rate,
    // so the pipe fills and s_tready has to drop. The 30-column grid also
    // writes every store entry that the random sizes can reach, so size
    // changes mid-grid never read a store entry that was never written.
    tx_gaps = 1'b0;
    set_reg(REG_INTERIOR_ROWS, 16'd6);
    set_reg(REG_INTERIOR_COLS, 16'd30);
    set_reg(REG_COEFF_ROWS, pick_coeff());
    set_reg(REG_COEFF_COLS, pick_coeff());
    rx_hold_req = 1'b1;
    send_grid(sb.grid_words(), 1'b1, 1'b0);
    finish_phase();

    // Random phases: new settings, then mostly well-formed grids with some
    // missing start marks, truncated grids and stray restarts. A phase that
    // ends on a truncated grid makes the next size change land mid-grid.
    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) < 7) set_reg(REG_COEFF_ROWS, pick_coeff());
      if ($urandom_range(0, 9) < 7) set_reg(REG_COEFF_COLS, pick_coeff());
      if ($urandom_range(0, 9) < 7) set_reg(REG_INTERIOR_ROWS, pick_dim());
      if ($urandom_range(0, 9) < 7) set_reg(REG_INTERIOR_COLS, pick_dim());
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      grids   = $urandom_range(1, 4);
      for (int g = 0; g < grids; g++) begin
        full = sb.grid_words();
        kind = $urandom_range(0, 9);
        if (kind < 6)      send_grid(full, 1'b1, 1'b0);
        else if (kind < 7) send_grid(full, 1'b0, 1'b0);
        else if (kind < 9) send_grid($urandom_range(1, full - 1), 1'b1, 1'b0);
        else               send_grid(full, 1'($urandom_range(0, 1)), 1'b1);
      end
      finish_phase();
    end

    $display("run: %0d words in, %0d grid points checked over %0d phases",
             words_sent, sb.points_checked, phases);
    $display("rails, a clamped tall grid, restarts and cut grids; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
